// ===== rtl/hsv2rgb_pkg.sv =====
// shared types and constants for the hsv to rgb converter
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    // field widths
    localparam int HUE_W  = 9;
    localparam int PCT_W  = 7;
    localparam int CH_W   = 8;
    localparam int FRAC_W = 6;
    localparam int TERM_W = 13;
    localparam int NUM_W  = 20;

    // arithmetic constants
    localparam int SECTOR_SPAN = 60;
    localparam int PCT_FULL    = 100;
    localparam int TERM_SPAN   = SECTOR_SPAN * PCT_FULL;

    localparam logic [HUE_W-1:0]  HUE_MAX     = HUE_W'(359);
    localparam logic [PCT_W-1:0]  PCT_MAX     = PCT_W'(PCT_FULL);
    localparam logic [TERM_W-1:0] SPAN_T      = TERM_W'(SECTOR_SPAN);
    localparam logic [TERM_W-1:0] TERM_SPAN_T = TERM_W'(TERM_SPAN);

    // channel = floor(n * 255 / 600000) = floor(((n * 17) >> 6) / 625)
    // the divide by 625 is a multiply by ceil(2^28 / 625), exact for 18-bit operands
    localparam int SCALE_MUL   = 17;
    localparam int SCALE_SHIFT = 6;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_MULT  = 429497;
    localparam int RECIP_W     = 19;
    localparam int PRE_W       = 18;
    localparam int PROD_W      = PRE_W + RECIP_W;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t              sector;
        logic [FRAC_W-1:0]    frac;
        logic [PCT_W-1:0]     sat;
        logic [PCT_W-1:0]     val;
    } prep_t;

    typedef struct packed {
        sector_t              sector;
        logic [PCT_W-1:0]     val;
        logic [TERM_W-1:0]    a_p;
        logic [TERM_W-1:0]    a_q;
        logic [TERM_W-1:0]    a_t;
    } term_t;

    typedef struct packed {
        logic [NUM_W-1:0]     red;
        logic [NUM_W-1:0]     green;
        logic [NUM_W-1:0]     blue;
    } num_t;

endpackage

// ===== rtl/hsv_to_rgb_converter_top.sv =====
// hsv to rgb converter, top level with stream ports
`timescale 1ns / 1ps

// converts one pixel per clock from hue (degrees), saturation and value
// (percent) to 8-bit red, green and blue. the datapath is five register
// stages: clamp and sector split, p/q/t factors, value scaling with sector
// select, and a two-stage constant divide that scales by 255/600000 with
// truncation. a new request is taken every cycle, and each stage has its own
// valid bit and ready, so a stall on the result side fills the empty stages
// before the input side is held. out-of-range fields clamp: hue to 359,
// saturation and value to 100. the block has no state across pixels and no
// configuration.

module hsv_to_rgb_converter_top
    import hsv2rgb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // hue [8:0], saturation [15:9], brightness [22:16], zero [23]
    input  logic [23:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic [23:0]  m_axis_tdata
);

    // stage handshakes
    logic       prep_valid;
    logic       prep_ready;
    prep_t      prep_data;
    logic       num_valid;
    logic       num_ready;
    num_t       num_data;

    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    // clamp fields, find sector and fraction
    hsv2rgb_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_hue    (s_axis_tdata[HUE_W-1:0]),
        .in_sat    (s_axis_tdata[HUE_W +: PCT_W]),
        .in_val    (s_axis_tdata[HUE_W+PCT_W +: PCT_W]),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    // p, q, t numerators over 600000, routed to channels by sector
    hsv2rgb_terms u_terms (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (num_valid),
        .out_ready (num_ready),
        .out_data  (num_data)
    );

    // numerator * 255 / 600000, truncated; last stage is the output register
    hsv2rgb_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (num_valid),
        .in_ready  (num_ready),
        .in_data   (num_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_red   (red),
        .out_green (green),
        .out_blue  (blue)
    );

    assign m_axis_tdata = {blue, green, red};

endmodule

// ===== rtl/hsv2rgb_prep.sv =====
// input stage: clamps the fields and splits hue into sector and fraction
`timescale 1ns / 1ps

module hsv2rgb_prep
    import hsv2rgb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [HUE_W-1:0]  in_hue,
    input  logic [PCT_W-1:0]  in_sat,
    input  logic [PCT_W-1:0]  in_val,
    output logic              out_valid,
    input  logic              out_ready,
    output prep_t             out_data
);

    logic              valid_reg;
    prep_t             data_reg;
    prep_t             data_next;
    logic [HUE_W-1:0]  hue_c;
    logic [HUE_W-1:0]  base;
    logic [HUE_W-1:0]  frac_w;
    logic              load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        hue_c = (in_hue > HUE_MAX) ? HUE_MAX : in_hue;
        if (hue_c >= HUE_W'(5 * SECTOR_SPAN)) begin
            data_next.sector = SEC_MR;
            base = HUE_W'(5 * SECTOR_SPAN);
        end else if (hue_c >= HUE_W'(4 * SECTOR_SPAN)) begin
            data_next.sector = SEC_BM;
            base = HUE_W'(4 * SECTOR_SPAN);
        end else if (hue_c >= HUE_W'(3 * SECTOR_SPAN)) begin
            data_next.sector = SEC_CB;
            base = HUE_W'(3 * SECTOR_SPAN);
        end else if (hue_c >= HUE_W'(2 * SECTOR_SPAN)) begin
            data_next.sector = SEC_GC;
            base = HUE_W'(2 * SECTOR_SPAN);
        end else if (hue_c >= HUE_W'(SECTOR_SPAN)) begin
            data_next.sector = SEC_YG;
            base = HUE_W'(SECTOR_SPAN);
        end else begin
            data_next.sector = SEC_RY;
            base = '0;
        end
        frac_w         = hue_c - base;
        data_next.frac = frac_w[FRAC_W-1:0];
        data_next.sat  = (in_sat > PCT_MAX) ? PCT_MAX : in_sat;
        data_next.val  = (in_val > PCT_MAX) ? PCT_MAX : in_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // fraction within a sector never reaches the sector span
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ({{(HUE_W-FRAC_W){1'b0}}, data_reg.frac} < HUE_W'(SECTOR_SPAN)))
        else $error("sector fraction out of range");

endmodule

// ===== rtl/hsv2rgb_terms.sv =====
// two stages: p, q, t factors, then scaling by value and sector select
`timescale 1ns / 1ps

module hsv2rgb_terms
    import hsv2rgb_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  prep_t  in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output num_t   out_data
);

    logic              fac_valid_reg;
    term_t             fac_reg;
    term_t             fac_next;
    logic              fac_ready;
    logic              num_valid_reg;
    num_t              num_reg;
    num_t              num_next;
    logic [TERM_W-1:0] frac_w;
    logic [TERM_W-1:0] sat_w;
    logic [TERM_W-1:0] frac_inv;
    logic [NUM_W-1:0]  val_w;
    logic [NUM_W-1:0]  nv;
    logic [NUM_W-1:0]  np;
    logic [NUM_W-1:0]  nq;
    logic [NUM_W-1:0]  nt;

    assign fac_ready = !num_valid_reg || out_ready;
    assign in_ready  = !fac_valid_reg || fac_ready;

    // factors over 6000: p = 60*(100-s), q = 6000-f*s, t = 6000-(60-f)*s
    always_comb begin
        frac_w          = TERM_W'(in_data.frac);
        sat_w           = TERM_W'(in_data.sat);
        frac_inv        = SPAN_T - frac_w;
        fac_next.sector = in_data.sector;
        fac_next.val    = in_data.val;
        fac_next.a_p    = (TERM_W'(PCT_MAX) - sat_w) * SPAN_T;
        fac_next.a_q    = TERM_SPAN_T - frac_w * sat_w;
        fac_next.a_t    = TERM_SPAN_T - frac_inv * sat_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fac_valid_reg <= 1'b0;
        end else if (in_ready) begin
            fac_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            fac_reg <= fac_next;
        end
    end

    always_comb begin
        val_w = NUM_W'(fac_reg.val);
        nv    = val_w * NUM_W'(TERM_SPAN_T);
        np    = val_w * NUM_W'(fac_reg.a_p);
        nq    = val_w * NUM_W'(fac_reg.a_q);
        nt    = val_w * NUM_W'(fac_reg.a_t);
        case (fac_reg.sector)
            SEC_RY: begin num_next.red = nv; num_next.green = nt; num_next.blue = np; end
            SEC_YG: begin num_next.red = nq; num_next.green = nv; num_next.blue = np; end
            SEC_GC: begin num_next.red = np; num_next.green = nv; num_next.blue = nt; end
            SEC_CB: begin num_next.red = np; num_next.green = nq; num_next.blue = nv; end
            SEC_BM: begin num_next.red = nt; num_next.green = np; num_next.blue = nv; end
            default: begin num_next.red = nv; num_next.green = np; num_next.blue = nq; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_valid_reg <= 1'b0;
        end else if (fac_ready) begin
            num_valid_reg <= fac_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fac_valid_reg && fac_ready) begin
            num_reg <= num_next;
        end
    end

    assign out_valid = num_valid_reg;
    assign out_data  = num_reg;

    // no factor exceeds the full term span
    a_fac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fac_valid_reg |-> (fac_reg.a_p <= TERM_SPAN_T && fac_reg.a_q <= TERM_SPAN_T
                           && fac_reg.a_t <= TERM_SPAN_T))
        else $error("term factor above span");

endmodule

// ===== rtl/hsv2rgb_scale.sv =====
// two stages: scales term numerators to 8-bit channels by 255/600000
`timescale 1ns / 1ps

module hsv2rgb_scale
    import hsv2rgb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  num_t             in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CH_W-1:0]  out_red,
    output logic [CH_W-1:0]  out_green,
    output logic [CH_W-1:0]  out_blue
);

    localparam int X_W = NUM_W + 5;

    // (n * 17) >> 6
    function automatic logic [PRE_W-1:0] pre_scale(input logic [NUM_W-1:0] n);
        logic [X_W-1:0] x;
        x = X_W'(n) * X_W'(SCALE_MUL);
        return PRE_W'(x >> SCALE_SHIFT);
    endfunction

    function automatic logic [CH_W-1:0] recip(input logic [PRE_W-1:0] y);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(y) * PROD_W'(RECIP_MULT);
        return prod[RECIP_SHIFT +: CH_W];
    endfunction

    logic              pre_valid_reg;
    logic              pre_ready;
    logic [PRE_W-1:0]  red_pre_reg;
    logic [PRE_W-1:0]  green_pre_reg;
    logic [PRE_W-1:0]  blue_pre_reg;
    logic              ch_valid_reg;
    logic [CH_W-1:0]   red_reg;
    logic [CH_W-1:0]   green_reg;
    logic [CH_W-1:0]   blue_reg;

    assign pre_ready = !ch_valid_reg || out_ready;
    assign in_ready  = !pre_valid_reg || pre_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
            ch_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                pre_valid_reg <= in_valid;
            end
            if (pre_ready) begin
                ch_valid_reg <= pre_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            red_pre_reg   <= pre_scale(in_data.red);
            green_pre_reg <= pre_scale(in_data.green);
            blue_pre_reg  <= pre_scale(in_data.blue);
        end
        if (pre_valid_reg && pre_ready) begin
            red_reg   <= recip(red_pre_reg);
            green_reg <= recip(green_pre_reg);
            blue_reg  <= recip(blue_pre_reg);
        end
    end

    assign out_valid = ch_valid_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !ch_valid_reg)
        else $error("output valid after reset");

    // a held result keeps its channels while the output side is not ready
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ch_valid_reg && !out_ready |=> ch_valid_reg && $stable(red_reg)
            && $stable(green_reg) && $stable(blue_reg))
        else $error("stalled result changed");

    // a stalled pre-scale stage must not be overwritten
    a_pre_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        pre_valid_reg && !pre_ready |=> pre_valid_reg && $stable(red_pre_reg)
            && $stable(green_pre_reg) && $stable(blue_pre_reg))
        else $error("stalled pre-scale stage changed");

endmodule
